// ===== design/tww_pkg.sv =====
// Shared types, codes and the wheel bucket function of the timer manager.
`timescale 1ns / 1ps

package tww_pkg;

	localparam int SLOTS_DEFAULT = 16;
	localparam int MAX_RESULTS = 16;
	localparam int TIME_W = 32;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_ARM = 2'd1;
	localparam logic [1:0] MODE_REARM = 2'd2;

	localparam logic [5:0] LEVEL_MASK = 6'h3F;

	// One timer slot as it travels along the ring.
	typedef struct packed {
		logic [TIME_W-1:0] expiry;
		logic [TIME_W-1:0] period;
		logic rep;
		logic active;
	} slot_rec_t;

	// Controls handed to the head unit for the slot currently at the ring head.
	typedef struct packed {
		logic [1:0] op;
		logic match;
		logic room;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] req_period;
		logic req_rep;
	} head_ctl_t;

	// Level in bits 10:8, index in bits 7:0.
	function automatic logic [10:0] bucket_of(input logic [TIME_W-1:0] t);
		logic [10:0] b;
		if (t[31:8] == 24'd0) begin
			b = {3'd0, t[7:0]};
		end else if (t[31:14] == 18'd0) begin
			b = {3'd1, 2'b00, t[13:8] & LEVEL_MASK};
		end else if (t[31:20] == 12'd0) begin
			b = {3'd2, 2'b00, t[19:14] & LEVEL_MASK};
		end else if (t[31:26] == 6'd0) begin
			b = {3'd3, 2'b00, t[25:20] & LEVEL_MASK};
		end else begin
			b = {3'd4, 2'b00, t[31:26] & LEVEL_MASK};
		end
		return b;
	endfunction

endpackage

// ===== design/tww_cell.sv =====
// One ring cell holding a single timer slot record.
`timescale 1ns / 1ps

module tww_cell
	import tww_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  slot_rec_t d,
	output slot_rec_t q
);

	slot_rec_t rec_q;
	logic act_q;

	// Only the active flag has a defined reset; the rest is valid once armed.
	always_ff @(posedge clk) begin
		if (en) begin
			rec_q <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (en) begin
			act_q <= d.active;
		end
	end

	always_comb begin
		q = rec_q;
		q.active = act_q;
	end

endmodule

// ===== design/tww_head.sv =====
// Head unit: decides firing and computes the updated record of the head slot.
`timescale 1ns / 1ps

module tww_head
	import tww_pkg::*;
(
	input  slot_rec_t rec_in,
	input  head_ctl_t ctl,
	output slot_rec_t rec_out,
	output logic      fire
);

	logic due;
	logic [TIME_W-1:0] sum;

	always_comb begin
		due = rec_in.active && (bucket_of(rec_in.expiry) == bucket_of(ctl.now))
			&& (rec_in.expiry <= ctl.now);
		fire = (ctl.op == MODE_TICK) && due && ctl.room;
		sum = ctl.now + ((ctl.op == MODE_ARM) ? ctl.req_period : rec_in.period);

		rec_out = rec_in;
		case (ctl.op)
			MODE_ARM: begin
				if (ctl.match) begin
					rec_out.period = ctl.req_period;
					rec_out.rep = ctl.req_rep;
					rec_out.expiry = sum;
					rec_out.active = 1'b1;
				end
			end
			MODE_REARM: begin
				if (ctl.match) begin
					rec_out.expiry = sum;
					rec_out.active = 1'b1;
				end
			end
			MODE_TICK: begin
				if (fire) begin
					if (rec_in.rep) begin
						rec_out.expiry = sum;
					end else begin
						rec_out.active = 1'b0;
					end
				end
			end
			default: begin
				rec_out = rec_in;
			end
		endcase
	end

endmodule

// ===== design/timing_wheel_timer_manager.sv =====
// Top level of the timer manager: request channels, scan control and slot ring.
`timescale 1ns / 1ps

// Usage. One request channel (in_valid/in_ready) carries mode, slot, period and
// repeat_req. Mode tick advances the current time by one and reports every due
// timer; mode arm stores a period and repeat flag for a slot and sets its expiry
// to now plus the period; mode rearm does the same with the stored period.
// Arm and rearm produce no result; an unused mode or an out-of-range slot is
// dropped when it is taken. The result channel (out_valid/out_ready) carries one
// request per fired slot, in slot order, with last set on the final one; a tick
// that fires nothing yields a single request with fired low and last high.
// Occupancy: the slot records sit in a ring of SLOTS cells that rotates one
// place per cycle, while not stalled, past a single head unit, so arm and
// rearm occupy the block for the accepting cycle plus one turn of the ring,
// and a tick additionally passes through the done state, which hands over its
// final result. The first fired result of a tick appears once the next firing
// slot or the end of the scan is reached, since last must be known.
// When the receiver stalls, the ring halts on the next firing slot until the
// output register frees; a new request is taken as soon as the final result is
// loaded, even while it still waits in the output register.
// Reset clears the current time and marks every slot inactive at once.

module timing_wheel_timer_manager
	import tww_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [3:0]  slot,
	input  logic [31:0] period,
	input  logic        repeat_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        fired,
	output logic [3:0]  fired_slot,
	output logic [31:0] now_time,
	output logic        last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SW = (IW > 4) ? IW : 4;
	localparam int NW = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	state_t state_q;
	logic [1:0] op_q;
	logic [SW-1:0] slot_q;
	logic [31:0] period_q;
	logic rep_q;
	logic [IW-1:0] cnt_q;
	logic [31:0] now_q;
	logic pend_v_q;
	logic [3:0] pend_slot_q;
	logic [NW-1:0] nfire_q;
	logic out_v_q;
	logic fired_q;
	logic [3:0] fired_slot_q;
	logic [31:0] now_time_q;
	logic last_q;

	slot_rec_t ring_q [SLOTS];
	slot_rec_t ring_d [SLOTS];
	slot_rec_t head_next;
	head_ctl_t ctl;
	logic fire;
	logic out_busy;
	logic stall;
	logic shift;
	logic out_load;
	logic [SW-1:0] cnt_ext;
	logic slot_ok;

	assign cnt_ext = SW'(cnt_q);
	assign out_busy = out_v_q && !out_ready;
	assign slot_ok = {28'd0, slot} < 32'(SLOTS);

	always_comb begin
		ctl.op = op_q;
		ctl.match = (cnt_ext == slot_q);
		ctl.room = (nfire_q < NW'(MAX_RESULTS));
		ctl.now = now_q;
		ctl.req_period = period_q;
		ctl.req_rep = rep_q;
	end

	tww_head u_head (
		.rec_in  (ring_q[0]),
		.ctl     (ctl),
		.rec_out (head_next),
		.fire    (fire)
	);

	// A firing slot must push the held result out; if the output register is
	// still occupied the ring waits on this slot.
	assign stall = fire && pend_v_q && out_busy;
	assign shift = (state_q == ST_SCAN) && !stall;

	// The output register takes a new result either when a later firing slot
	// releases the held one or when the scan has ended.
	assign out_load = (shift && fire && pend_v_q) || ((state_q == ST_DONE) && !out_busy);

	// The ring closes through the head unit: the head record goes, updated,
	// to the far end, so a full pass of SLOTS shifts restores the order.
	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_ring
			if (gi == SLOTS - 1) begin : g_tail
				assign ring_d[gi] = head_next;
			end else begin : g_mid
				assign ring_d[gi] = ring_q[gi+1];
			end
			tww_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (shift),
				.d      (ring_d[gi]),
				.q      (ring_q[gi])
			);
		end
	endgenerate

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= MODE_TICK;
			slot_q <= '0;
			period_q <= '0;
			rep_q <= 1'b0;
			cnt_q <= '0;
			now_q <= '0;
			pend_v_q <= 1'b0;
			pend_slot_q <= '0;
			nfire_q <= '0;
			out_v_q <= 1'b0;
			fired_q <= 1'b0;
			fired_slot_q <= '0;
			now_time_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q <= mode;
						slot_q <= SW'(slot);
						period_q <= period;
						rep_q <= repeat_req;
						cnt_q <= '0;
						if (mode == MODE_TICK) begin
							now_q <= now_q + 32'd1;
							nfire_q <= '0;
							pend_v_q <= 1'b0;
							state_q <= ST_SCAN;
						end else if ((mode == MODE_ARM || mode == MODE_REARM) && slot_ok) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (shift) begin
						if (fire) begin
							nfire_q <= nfire_q + NW'(1);
							if (pend_v_q) begin
								fired_q <= 1'b1;
								fired_slot_q <= pend_slot_q;
								now_time_q <= now_q;
								last_q <= 1'b0;
							end
							pend_v_q <= 1'b1;
							pend_slot_q <= cnt_ext[3:0];
						end
						if (cnt_q == IW'(SLOTS - 1)) begin
							cnt_q <= '0;
							state_q <= (op_q == MODE_TICK) ? ST_DONE : ST_IDLE;
						end else begin
							cnt_q <= cnt_q + IW'(1);
						end
					end
				end
				ST_DONE: begin
					if (!out_busy) begin
						fired_q <= pend_v_q;
						fired_slot_q <= pend_v_q ? pend_slot_q : 4'd0;
						now_time_q <= now_q;
						last_q <= 1'b1;
						pend_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign fired = fired_q;
	assign fired_slot = fired_slot_q;
	assign now_time = now_time_q;
	assign last = last_q;

endmodule

// ===== test/tb_timing_wheel_timer_manager.sv =====
// Self-checking testbench for the timing wheel timer manager.
`timescale 1ns / 1ps

// The bench drives tick, arm and rearm requests into the manager and checks
// every result request against its own prediction of the slot table.
//
// A directed table runs first. It covers the first tick after reset, an
// ignored unused mode, one-shot and repeating timers, rearm from the stored
// period, and the period extremes. A period of zero and the all-ones period
// wrap the expiry onto, or just before, the current time. Rows whose result
// is obvious carry it typed in. All other rows go through the predictor.
//
// The random part is mostly ticks mixed with arms of small periods, so that
// timers really fire. Some arms use wrapping or huge periods, which place
// the expiry in a wheel bucket that may never match again. Now and then a
// burst arms all sixteen slots for the same expiry, which gives a tick with
// the largest number of results. Rearm is only issued for a slot whose
// period has been written, since the stored period is undefined before that.
//
// The request and result sides both pause in random bursts. Near the end of
// the run both sides run without pauses.

module tb_timing_wheel_timer_manager;
	import tww_pkg::*;

	localparam int NUM_TIMERS = 16;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int NUM_DIRECTED = 20;
	localparam int RANDOM_ITEMS = 460;
	localparam int CALM_TAIL = 40;
	localparam int SETTLE_CYCLES = 2 * NUM_TIMERS + 8;
	localparam int CYCLE_LIMIT = 1000000;

	// One request as the manager takes it.
	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] slot;
		logic [31:0] period;
		logic repeat_req;
	} timer_req_t;

	// One result request as the manager sends it.
	typedef struct packed {
		logic fired;
		logic [3:0] fired_slot;
		logic [31:0] now_time;
		logic last;
	} firing_t;

	// A row of the directed table. When typed is set, exp_first is the whole
	// expected outcome of a tick that gives exactly one result.
	typedef struct packed {
		timer_req_t req;
		logic typed;
		firing_t exp_first;
	} directed_row_t;

	localparam firing_t NO_TYPED = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = MODE_TICK;
	logic [3:0] slot = 4'd0;
	logic [31:0] period = 32'd0;
	logic repeat_req = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic fired;
	logic [3:0] fired_slot;
	logic [31:0] now_time;
	logic last;

	// Predicted state of the slot table.
	logic [31:0] wheel_now = 32'd0;
	logic [31:0] timer_expiry [NUM_TIMERS];
	logic [31:0] timer_period [NUM_TIMERS];
	logic timer_repeat [NUM_TIMERS];
	logic timer_armed [NUM_TIMERS];
	logic period_known [NUM_TIMERS];

	// Results of the request just predicted, and every result still awaited.
	firing_t fresh_firings [$];
	firing_t pending_firings [$];

	int error_count = 0;
	int cycle_count = 0;
	int items_sent = 0;
	logic quiet_tail = 1'b0;
	int ready_hold = 0;

	directed_row_t directed_rows [NUM_DIRECTED] = '{
		// First tick after reset: nothing is armed, time goes to one.
		'{'{MODE_TICK, 4'd0, 32'd0, 1'b0}, 1'b1, '{1'b0, 4'd0, 32'd1, 1'b1}},
		// The unused mode is dropped without a result.
		'{'{MODE_UNUSED, 4'd15, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_TYPED},
		// A one-shot timer one tick ahead fires once and then stays quiet.
		'{'{MODE_ARM, 4'd0, 32'd1, 1'b0}, 1'b0, NO_TYPED},
		'{'{MODE_TICK, 4'd0, 32'd0, 1'b0}, 1'b1, '{1'b1, 4'd0, 32'd2, 1'b1}},
		'{'{MODE_TICK, 4'd0, 32'd0, 1'b0}, 1'b1, '{1'b0, 4'd0, 32'd3, 1'b1}},
		// All-ones and zero periods put the expiry behind the next tick.
		'{'{MODE_ARM, 4'd15, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_TYPED},
		'{'{MODE_ARM, 4'd5, 32'd0, 1'b1}, 1'b0, NO_TYPED},
		// Two timers due on the same tick, one repeating and one not.
		'{'{MODE_ARM, 4'd3, 32'd2, 1'b1}, 1'b0, NO_TYPED},
		'{'{MODE_ARM, 4'd10, 32'd2, 1'b0}, 1'b0, NO_TYPED},
		'{'{MODE_TICK, 4'd0, 32'd0, 1'b0}, 1'b0, NO_TYPED},
		'{'{MODE_TICK, 4'd9, 32'h1234_5678, 1'b1}, 1'b0, NO_TYPED},
		'{'{MODE_REARM, 4'd10, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_TYPED},
		'{'{MODE_TICK, 4'd0, 32'd0, 1'b0}, 1'b0, NO_TYPED},
		'{'{MODE_TICK, 4'd0, 32'd0, 1'b0}, 1'b0, NO_TYPED},
		// Far-future expiries at the upper levels of the wheel.
		'{'{MODE_ARM, 4'd8, 32'h8000_0000, 1'b0}, 1'b0, NO_TYPED},
		'{'{MODE_ARM, 4'd6, 32'h7FFF_FFFF, 1'b1}, 1'b0, NO_TYPED},
		'{'{MODE_REARM, 4'd15, 32'd0, 1'b0}, 1'b0, NO_TYPED},
		'{'{MODE_TICK, 4'd0, 32'd0, 1'b0}, 1'b0, NO_TYPED},
		'{'{MODE_ARM, 4'd12, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_TYPED},
		'{'{MODE_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_TYPED}
	};

	timing_wheel_timer_manager DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.slot(slot),
		.period(period),
		.repeat_req(repeat_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fired(fired),
		.fired_slot(fired_slot),
		.now_time(now_time),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Wheel bucket of a time: level in the top three bits, index below.
	// Level 0 is exact; the others keep six bits of the time.
	function automatic logic [10:0] wheel_bucket(input logic [31:0] t);
		logic [2:0] level;
		logic [31:0] shifted;
		if (t < 32'h0000_0100) begin
			return {3'd0, t[7:0]};
		end
		if (t < 32'h0000_4000) begin
			level = 3'd1;
			shifted = t >> 8;
		end else if (t < 32'h0010_0000) begin
			level = 3'd2;
			shifted = t >> 14;
		end else if (t < 32'h0400_0000) begin
			level = 3'd3;
			shifted = t >> 20;
		end else begin
			level = 3'd4;
			shifted = t >> 26;
		end
		return {level, 2'b00, shifted[5:0]};
	endfunction

	// Updates the predicted table for one request and leaves its results in
	// fresh_firings.
	function automatic void apply_timer_request(input timer_req_t r);
		logic [10:0] now_bucket;
		logic [NUM_TIMERS-1:0] due;
		int last_due;
		fresh_firings.delete();
		due = '0;
		last_due = -1;
		case (r.mode)
		MODE_ARM, MODE_REARM: begin
			if (r.mode == MODE_ARM) begin
				timer_period[r.slot] = r.period;
				timer_repeat[r.slot] = r.repeat_req;
				period_known[r.slot] = 1'b1;
			end
			timer_expiry[r.slot] = wheel_now + timer_period[r.slot];
			timer_armed[r.slot] = 1'b1;
		end
		MODE_TICK: begin
			wheel_now = wheel_now + 32'd1;
			now_bucket = wheel_bucket(wheel_now);
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (timer_armed[i] && wheel_bucket(timer_expiry[i]) == now_bucket
						&& timer_expiry[i] <= wheel_now) begin
					if (timer_repeat[i]) begin
						timer_expiry[i] = wheel_now + timer_period[i];
					end else begin
						timer_armed[i] = 1'b0;
					end
					due[i] = 1'b1;
					last_due = i;
				end
			end
			if (last_due < 0) begin
				fresh_firings.push_back('{1'b0, 4'd0, wheel_now, 1'b1});
			end else begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (due[i]) begin
						fresh_firings.push_back('{1'b1, 4'(i), wheel_now, i == last_due});
					end
				end
			end
		end
		default: begin
		end
		endcase
	endfunction

	// Called at a falling edge. Optionally pauses, then presents the request
	// and holds it until the manager takes it. Returns at the next falling edge.
	task automatic issue_request(input timer_req_t r, input logic typed,
			input firing_t typed_exp);
		int gap;
		if (!quiet_tail && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode;
		slot <= r.slot;
		period <= r.period;
		repeat_req <= r.repeat_req;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		apply_timer_request(r);
		if (typed) begin
			pending_firings.push_back(typed_exp);
		end else begin
			foreach (fresh_firings[k]) begin
				pending_firings.push_back(fresh_firings[k]);
			end
		end
		@(negedge clk);
	endtask

	// A tick whose ignored fields carry noise.
	function automatic timer_req_t random_tick();
		return '{MODE_TICK, 4'($urandom_range(0, 15)), 32'($urandom),
			1'($urandom_range(0, 1))};
	endfunction

	// Mostly short periods, so that timers fire within the run; sometimes
	// zero, a wrap to just before now, a full random word or a longer wait.
	function automatic logic [31:0] random_period();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
		6: return 32'd0;
		7: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
		8: return 32'($urandom);
		9: return 32'($urandom_range(200, 1000));
		default: return 32'($urandom_range(0, 24));
		endcase
	endfunction

	initial begin
		timer_req_t req;
		int pick;
		int burst_period;
		int first_slot;
		int probe;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			timer_armed[i] = 1'b0;
			period_known[i] = 1'b0;
		end
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < NUM_DIRECTED; r++) begin
			issue_request(directed_rows[r].req, directed_rows[r].typed,
				directed_rows[r].exp_first);
		end

		while (items_sent < RANDOM_ITEMS) begin
			quiet_tail <= (items_sent >= RANDOM_ITEMS - CALM_TAIL);
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				// Unused mode: noise that the manager must drop.
				req = '{MODE_UNUSED, 4'($urandom_range(0, 15)), 32'($urandom),
					1'($urandom_range(0, 1))};
				issue_request(req, 1'b0, NO_TYPED);
				items_sent++;
			end else if (pick < 6) begin
				// Arm every slot for the same tick, then tick up to it.
				burst_period = $urandom_range(1, 6);
				first_slot = $urandom_range(0, NUM_TIMERS - 1);
				for (int k = 0; k < NUM_TIMERS; k++) begin
					req = '{MODE_ARM, 4'(first_slot + k), 32'(burst_period),
						1'($urandom_range(0, 1))};
					issue_request(req, 1'b0, NO_TYPED);
				end
				repeat (burst_period) begin
					issue_request(random_tick(), 1'b0, NO_TYPED);
				end
				items_sent += NUM_TIMERS + burst_period;
			end else if (pick < 60) begin
				issue_request(random_tick(), 1'b0, NO_TYPED);
				items_sent++;
			end else begin
				req = '{MODE_ARM, 4'($urandom_range(0, 15)), random_period(),
					1'($urandom_range(0, 1))};
				if (pick < 72) begin
					// Rearm the first slot from a random start whose period
					// is known; fall back to an arm when none is.
					probe = $urandom_range(0, NUM_TIMERS - 1);
					for (int k = 0; k < NUM_TIMERS; k++) begin
						if (req.mode == MODE_ARM
								&& period_known[(probe + k) % NUM_TIMERS]) begin
							req.mode = MODE_REARM;
							req.slot = 4'((probe + k) % NUM_TIMERS);
						end
					end
				end
				issue_request(req, 1'b0, NO_TYPED);
				items_sent++;
			end
		end
		in_valid <= 1'b0;

		while (pending_firings.size() != 0) begin
			@(posedge clk);
		end
		// Any late result in this window is caught as unexpected.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_timing_wheel_timer_manager: done, clean");
		end else begin
			$display("tb_timing_wheel_timer_manager: done, errors");
		end
		$finish;
	end

	// Result side: stalls in random bursts, never in the calm tail.
	always @(negedge clk) begin
		if (quiet_tail) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 99) < 12) begin
			out_ready <= 1'b0;
			ready_hold <= $urandom_range(0, 14);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Every accepted result is checked against the oldest awaited one.
	always @(posedge clk) begin
		firing_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_firings.size() == 0) begin
				$error("unexpected result: fired %0d slot %0d now %0d last %0d",
					fired, fired_slot, now_time, last);
				error_count++;
			end else begin
				want = pending_firings.pop_front();
				if (fired !== want.fired) begin
					$error("fired: expected %0d, got %0d", want.fired, fired);
					error_count++;
				end
				if (fired_slot !== want.fired_slot) begin
					$error("fired_slot: expected %0d, got %0d", want.fired_slot,
						fired_slot);
					error_count++;
				end
				if (now_time !== want.now_time) begin
					$error("now_time: expected %0d, got %0d", want.now_time, now_time);
					error_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_timing_wheel_timer_manager: done, errors");
			$finish;
		end
	end

endmodule
